[design/rbcr_pkg.sv]
// Shared types and constants for the run-length bit clock recovery block.
// No dependencies; every other design file imports this package.
package rbcr_pkg;

	// Sizing
	localparam int MAX_RUN_BITS    = 32;
	localparam int CODE_WIDTH      = 22;
	localparam int RUN_COUNT_WIDTH = 16;

	// Fixed field widths
	localparam int RSSI_W     = 8;
	localparam int ACCESS_W   = 22;
	localparam int MAX_ERR_W  = 5;
	localparam int NOMINAL_W  = 16;
	localparam int MIN_RUN_W  = 4;
	localparam int CFG_DATA_W = 22;
	localparam int CFG_IDX_W  = 2;
	localparam int RAW_HIST_W = 6;
	localparam int BITLEN_W   = 31;
	localparam int ES_W       = 32;
	localparam int ES16_W     = ES_W - 4;
	localparam int SCALE_SH   = 8;
	localparam int DIV_SH     = 5;

	// Derived widths
	localparam int N_W      = $clog2(MAX_RUN_BITS + 1);
	localparam int SCALED_W = (RUN_COUNT_WIDTH + 9 > 32) ? RUN_COUNT_WIDTH + 9 : 32;
	localparam int NUM_W    = SCALED_W + 1;
	localparam int DIVD_W   = NUM_W - DIV_SH;
	localparam int UPD_W    = ((DIVD_W > BITLEN_W) ? DIVD_W : BITLEN_W) + 2;
	localparam int ESSUM_W  = ((SCALED_W > ES_W) ? SCALED_W : ES_W) + 1;

	// Register reset values
	localparam logic [ACCESS_W-1:0]  ACCESS_CODE_RST = 22'b0101010101010000111101;
	localparam logic [MAX_ERR_W-1:0] MAX_ERR_RST     = 5'd1;
	localparam logic [NOMINAL_W-1:0] NOMINAL_RST     = 16'd2048;
	localparam logic [MIN_RUN_W-1:0] MIN_RUN_RST     = 4'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACCESS_CODE = 2'd0,
		REG_MAX_ERRORS  = 2'd1,
		REG_NOMINAL_LEN = 2'd2,
		REG_MIN_RUN     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic              raw_bit;
		logic [RSSI_W-1:0] rssi;
	} in_beat_t;

	typedef struct packed {
		logic              data_bit;
		logic              code_found;
		logic              restart;
		logic [RSSI_W-1:0] strength;
		logic              last;
	} out_beat_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [N_W-1:0]    divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

[design/rbcr_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on rbcr_pkg for the request and response structs.
module rbcr_div
	import rbcr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVD_W-1:0] quo_q;
	logic [N_W-1:0]    rem_q;
	logic [N_W-1:0]    dvs_q;
	logic [N_W:0]      partial;
	logic [N_W:0]      trial;
	logic              qbit;

	always_comb begin
		partial = {rem_q, quo_q[DIVD_W-1]};
		trial   = partial - {1'b0, dvs_q};
		qbit    = ~trial[N_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIVD_W);
			quo_q  <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? trial[N_W-1:0] : partial[N_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], qbit};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule

[design/rbcr_match.sv]
// Access code matcher: counts mismatching bits against the sync word.
// Depends on rbcr_pkg for widths.
module rbcr_match
	import rbcr_pkg::*;
(
	input  logic [CODE_WIDTH-1:0] history,
	input  logic [ACCESS_W-1:0]   code,
	input  logic [MAX_ERR_W-1:0]  max_errors,
	output logic                  found
);

	localparam int CNT_W = $clog2(CODE_WIDTH + 1);
	localparam int CMP_W = (CNT_W > MAX_ERR_W) ? CNT_W : MAX_ERR_W;

	logic [CODE_WIDTH-1:0] diff;
	logic [CNT_W-1:0]      mism;

	always_comb begin
		diff = history ^ CODE_WIDTH'(code);
		mism = '0;
		for (int i = 0; i < CODE_WIDTH; i++) begin
			mism = mism + CNT_W'(diff[i]);
		end
		found = (CMP_W'(mism) <= CMP_W'(max_errors));
	end

endmodule

[design/runlength_bit_clock_recovery.sv]
// Top level of the run-length bit clock recovery block: sequencer, state, output register.
// Depends on rbcr_pkg, rbcr_div and rbcr_match.
//
// One raw demodulated bit per input beat is deglitched (high when at least three of
// the last six samples are high) and runs of equal level are counted. A sample that
// continues the run leaves the sequencer idle, so such samples stream at one per
// clock. A level change stalls the input while S_CHECK checks the run; a run that
// is too short gives a single restart beat once the output register is free, and
// the block returns to idle. Otherwise the run is cut into bits, one recovered bit
// per cycle (up to 32, plus any output stall), then S_ESUM, S_ES16 and S_NUM do
// the PI arithmetic, S_START starts the divider, the bit-serial divider forms the
// magnitude of (residual + error_sum/16) / (32 * bits) as DIVD_W (28 by default)
// quotient bits, and S_DIV takes the quotient. A closed run holds the input
// stalled until the quotient is taken.
// Output beats sit in a register, so a new sample is taken while the final beat
// of a run still waits downstream.
// Configuration may be written at any time but is meant for idle periods;
// nominal_bit_length takes effect at the next restart.
module runlength_bit_clock_recovery
	import rbcr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_beat_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_beat_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_CHECK = 8'b0000_0010,
		S_EMIT  = 8'b0000_0100,
		S_ESUM  = 8'b0000_1000,
		S_ES16  = 8'b0001_0000,
		S_NUM   = 8'b0010_0000,
		S_START = 8'b0100_0000,
		S_DIV   = 8'b1000_0000
	} state_t;

	// Configuration registers
	logic [ACCESS_W-1:0]  access_code_q;
	logic [MAX_ERR_W-1:0] max_err_q;
	logic [NOMINAL_W-1:0] nominal_q;
	logic [MIN_RUN_W-1:0] min_run_q;

	// Recovery state
	state_t                      state_q;
	logic [RAW_HIST_W-1:0]       raw_hist_q;
	logic                        level_q;
	logic [RUN_COUNT_WIDTH-1:0]  run_count_q;
	logic [BITLEN_W-1:0]         bit_len_q;
	logic signed [ES_W-1:0]      err_sum_q;
	logic [CODE_WIDTH-1:0]       bit_hist_q;

	// Per-run working registers
	logic                        now_q;
	logic [RSSI_W-1:0]           rssi_q;
	logic signed [SCALED_W-1:0]  scaled_q;
	logic [N_W-1:0]              n_q;
	logic signed [ES16_W-1:0]    es16_q;
	logic signed [NUM_W-1:0]     num_q;
	logic                        neg_q;

	// Output register
	logic                        out_valid_q;
	out_beat_t                   out_q;

	// Combinational helpers
	logic                        in_fire;
	logic                        out_free;
	logic                        out_load;
	logic [RAW_HIST_W-1:0]       raw_next;
	logic [$clog2(RAW_HIST_W+1)-1:0] raw_ones;
	logic                        now;
	logic [BITLEN_W-2:0]         half;
	logic [SCALED_W-1:0]         scaled0;
	logic                        resync;
	logic [BITLEN_W-1:0]         nominal_len;
	logic signed [SCALED_W:0]    scaled_sub;
	logic signed [SCALED_W-1:0]  scaled_next;
	logic [N_W-1:0]              n_next;
	logic                        more_bits;
	logic [CODE_WIDTH-1:0]       hist_next;
	logic                        found;
	logic signed [ESSUM_W-1:0]   es_sum;
	logic signed [ES_W-1:0]      es_sat;
	logic signed [ES_W-1:0]      es_bias;
	logic [NUM_W-1:0]            num_mag;
	logic signed [UPD_W-1:0]     upd;
	logic [BITLEN_W-1:0]         bit_len_new;
	div_req_t                    div_req;
	div_rsp_t                    div_rsp;

	assign in_fire   = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = ((state_q == S_CHECK) && resync && out_free)
	                   || ((state_q == S_EMIT) && out_free);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		// deglitch: high when at least three of the last six raw samples are high
		raw_next = {raw_hist_q[RAW_HIST_W-2:0], in_data.raw_bit};
		raw_ones = '0;
		for (int i = 0; i < RAW_HIST_W; i++) begin
			raw_ones = raw_ones + ($bits(raw_ones))'(raw_next[i]);
		end
		now = (raw_ones >= ($bits(raw_ones))'(3));

		// run check
		half        = bit_len_q[BITLEN_W-1:1];
		scaled0     = SCALED_W'({run_count_q, {SCALE_SH{1'b0}}});
		resync      = (run_count_q < RUN_COUNT_WIDTH'(min_run_q))
		              || (scaled0 <= SCALED_W'(half));
		nominal_len = (nominal_q == '0) ? BITLEN_W'(1) : BITLEN_W'(nominal_q);

		// one bit cut from the run
		scaled_sub  = (SCALED_W+1)'(scaled_q) - (SCALED_W+1)'(bit_len_q);
		scaled_next = scaled_sub[SCALED_W-1:0];
		n_next      = n_q + 1'b1;
		more_bits   = ($signed(scaled_next) > $signed(SCALED_W'(half)))
		              && (n_next < N_W'(MAX_RUN_BITS));
		hist_next   = {bit_hist_q[CODE_WIDTH-2:0], level_q};

		// integral term, saturated to 32 bits signed
		es_sum = ESSUM_W'(err_sum_q) + ESSUM_W'(scaled_q);
		if ((es_sum[ESSUM_W-1:ES_W-1] == '0) || (es_sum[ESSUM_W-1:ES_W-1] == '1)) begin
			es_sat = es_sum[ES_W-1:0];
		end else if (es_sum[ESSUM_W-1]) begin
			es_sat = {1'b1, {(ES_W-1){1'b0}}};
		end else begin
			es_sat = {1'b0, {(ES_W-1){1'b1}}};
		end

		// divide by 16 truncating toward zero: bias negatives before the shift
		es_bias = err_sum_q + (err_sum_q[ES_W-1] ? ES_W'(15) : ES_W'(0));

		num_mag = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);

		div_req.start    = (state_q == S_START);
		div_req.dividend = num_mag[NUM_W-1:DIV_SH];
		div_req.divisor  = n_q;

		// apply the correction with sign, then clamp to 1 .. 2^31-1
		upd = neg_q ? (UPD_W'(bit_len_q) - UPD_W'(div_rsp.quotient))
		            : (UPD_W'(bit_len_q) + UPD_W'(div_rsp.quotient));
		if (upd[UPD_W-1] || (upd == '0)) begin
			bit_len_new = BITLEN_W'(1);
		end else if (|upd[UPD_W-2:BITLEN_W]) begin
			bit_len_new = '1;
		end else begin
			bit_len_new = upd[BITLEN_W-1:0];
		end
	end

	rbcr_match u_match (
		.history    (hist_next),
		.code       (access_code_q),
		.max_errors (max_err_q),
		.found      (found)
	);

	rbcr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			access_code_q <= ACCESS_CODE_RST;
			max_err_q     <= MAX_ERR_RST;
			nominal_q     <= NOMINAL_RST;
			min_run_q     <= MIN_RUN_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ACCESS_CODE: access_code_q <= cfg_wdata[ACCESS_W-1:0];
				REG_MAX_ERRORS:  max_err_q     <= cfg_wdata[MAX_ERR_W-1:0];
				REG_NOMINAL_LEN: nominal_q     <= cfg_wdata[NOMINAL_W-1:0];
				REG_MIN_RUN:     min_run_q     <= cfg_wdata[MIN_RUN_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and recovery state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			raw_hist_q  <= '0;
			level_q     <= 1'b0;
			run_count_q <= '0;
			bit_len_q   <= BITLEN_W'(NOMINAL_RST);
			err_sum_q   <= '0;
			bit_hist_q  <= '0;
			now_q       <= 1'b0;
			rssi_q      <= '0;
			scaled_q    <= '0;
			n_q         <= '0;
			es16_q      <= '0;
			num_q       <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// raise valid on a new beat, drop it once the held beat is taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						raw_hist_q <= raw_next;
						if (now == level_q) begin
							if (run_count_q != '1) begin
								run_count_q <= run_count_q + 1'b1;
							end
						end else begin
							now_q   <= now;
							rssi_q  <= in_data.rssi;
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (resync) begin
						if (out_free) begin
							// restart beat, then reset recovery state: new run at the new level, nominal bit length
							out_q.data_bit      <= 1'b0;
							out_q.code_found    <= 1'b0;
							out_q.restart       <= 1'b1;
							out_q.strength      <= rssi_q;
							out_q.last          <= 1'b1;
							raw_hist_q          <= '0;
							level_q             <= now_q;
							run_count_q         <= RUN_COUNT_WIDTH'(1);
							bit_len_q           <= nominal_len;
							err_sum_q           <= '0;
							bit_hist_q          <= '0;
							state_q             <= S_IDLE;
						end
					end else begin
						scaled_q <= scaled0;
						n_q      <= '0;
						state_q  <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_q.data_bit   <= level_q;
						out_q.code_found <= found;
						out_q.restart    <= 1'b0;
						out_q.strength   <= rssi_q;
						out_q.last       <= !more_bits;
						scaled_q         <= scaled_next;
						bit_hist_q       <= hist_next;
						n_q              <= n_next;
						if (!more_bits) begin
							state_q <= S_ESUM;
						end
					end
				end
				S_ESUM: begin
					err_sum_q <= es_sat;
					state_q   <= S_ES16;
				end
				S_ES16: begin
					es16_q  <= es_bias[ES_W-1:4];
					state_q <= S_NUM;
				end
				S_NUM: begin
					num_q   <= NUM_W'(scaled_q) + NUM_W'(es16_q);
					state_q <= S_START;
				end
				S_START: begin
					neg_q   <= num_q[NUM_W-1];
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						bit_len_q   <= bit_len_new;
						level_q     <= now_q;
						run_count_q <= RUN_COUNT_WIDTH'(1);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_restart_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.restart |-> out_q.last && !out_q.data_bit && !out_q.code_found)
		else $error("restart beat carries data or is not final");

	a_bit_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		bit_len_q != '0)
		else $error("bit length reached zero");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> n_q < N_W'(MAX_RUN_BITS))
		else $error("too many bits cut from one run");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> div_req.divisor != '0)
		else $error("divider started with zero bit count");

endmodule
